// ===== src/split_node_pillar_corner_expander_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pillar corner expander
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPLIT_NODE_PILLAR_CORNER_EXPANDER_MACROS_SVH
`define SPLIT_NODE_PILLAR_CORNER_EXPANDER_MACROS_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle
`define SNPCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle
`define SNPCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SNPCE_ASSERT_IMP(label, ante, cons, msg)
`define SNPCE_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== src/snpce_pkg.sv =====
// ----------------------------------------------------------------------------
// snpce_pkg
// Shared constants and types of the pillar corner expander.
// ----------------------------------------------------------------------------
package snpce_pkg;

    // Field widths
    localparam int SPLIT_W  = 8;
    localparam int DEPTH_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CORNERS  = 4;
    localparam int ROW_W    = CORNERS * DEPTH_W;
    localparam int IN_W     = SPLIT_W + ROW_W;

    // Split codes
    localparam logic [SPLIT_W-1:0] SPLIT_SINGLE = 8'd1;
    localparam logic [SPLIT_W-1:0] SPLIT_QUAD   = 8'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_PER_PILLAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_OFFSET         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE          = 2'd2;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0] NODES_RESET  = 7'd16;
    localparam logic [DEPTH_W-1:0] OFFSET_RESET = 32'd0;
    localparam logic [DEPTH_W-1:0] SCALE_RESET  = 32'd65536;

    // Rounding constant: half of 2^16
    localparam logic [64:0] ROUND_HALF = 65'h8000;

    typedef logic signed [DEPTH_W-1:0] depth_t;

endpackage

// ===== src/snpce_ram.sv =====
// ----------------------------------------------------------------------------
// snpce_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module snpce_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/split_node_pillar_corner_expander.sv =====
// ----------------------------------------------------------------------------
// split_node_pillar_corner_expander
// Scales the depths of pillar nodes and emits each pillar in reverse order.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one node per item: split code and four Q24.8 depths. Each used
//   depth becomes (z + z_offset) * z_scale, rounded and saturated to 32 bits.
//   m_* gives one item per node when a pillar completes, last node first,
//   with tlast on the first node; tuser flags a bad split code, which gives
//   one zero item with tlast set and drops the partial pillar.
//   cfg_* writes nodes_per_pillar, z_offset and z_scale; always ready.
// Sequence:
//   s_tready stays low while a node runs: one add, multiply, magnitude and
//   round step per used depth (one depth for split code 1, four for split
//   code 4) through the single scaling datapath, then the stack write. A
//   completing node then drains the pillar through the registered stack RAM
//   read and the output register. An error item waits for a free output.
// Reset: clears the node count and the output valid; registers return
//   to 16 nodes, offset 0 and scale 1.0. Stack contents are not cleared.
// Stall: a held output item stalls the drain; the next node is still taken
//   while the last item of a pillar waits.
// ----------------------------------------------------------------------------
`include "split_node_pillar_corner_expander_macros.svh"

module split_node_pillar_corner_expander
    import snpce_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Node input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // split_code[7:0], depth_a[39:8], depth_b[71:40], depth_c[103:72],
    // depth_d[135:104]
    input  logic [IN_W-1:0]      s_tdata,
    // Corner output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // corner_a[31:0], corner_b[63:32], corner_c[95:64], corner_d[127:96]
    output logic [ROW_W-1:0]     m_tdata,
    output logic                 m_tlast,   // last_of_pillar
    output logic                 m_tuser,   // status[0]
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DEPTH_W-1:0]   cfg_data
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_NODES);

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SUM   = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ABS   = 4'd3;
    localparam logic [3:0] ST_RND   = 4'd4;
    localparam logic [3:0] ST_WRITE = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_LOAD  = 4'd7;
    localparam logic [3:0] ST_ERR   = 4'd8;

    // Control registers
    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    logic [1:0]         corner_idx_reg, corner_idx_next;
    logic [AW-1:0]      drain_idx_reg, drain_idx_next;
    logic               out_valid_reg, out_valid_next;

    // Configuration registers
    logic [COUNT_W-1:0] nodes_cfg_reg;
    logic [DEPTH_W-1:0] offset_cfg_reg;
    logic [DEPTH_W-1:0] scale_cfg_reg;

    // Payload registers
    depth_t             depth_reg [CORNERS];
    logic               single_reg;
    logic signed [32:0] sum_reg, sum_next;
    logic signed [64:0] prod_reg, prod_next;
    logic [63:0]        absp_reg, absp_next;
    logic               neg_reg, neg_next;
    logic [DEPTH_W-1:0] corner_reg [CORNERS];
    logic [DEPTH_W-1:0] corner_val;
    logic [ROW_W-1:0]   out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_status_reg, out_status_next;

    // Helpers
    logic               in_accept;
    logic               out_free;
    logic [SPLIT_W-1:0] in_split;
    logic               split_ok;
    logic [COUNT_W-1:0] pillar_len;
    logic [COUNT_W-1:0] base_cnt;
    logic [COUNT_W-1:0] new_cnt;
    logic [ROW_W-1:0]   row_wdata;
    logic [ROW_W-1:0]   row_rdata;
    logic               ram_we;
    logic               ram_re;
    logic [64:0]        rounded;
    logic [48:0]        mag;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign in_split  = s_tdata[SPLIT_W-1:0];
    assign split_ok  = (in_split == SPLIT_SINGLE) || (in_split == SPLIT_QUAD);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Clamp the pillar length to 1..MAX_NODES
    always_comb
    begin
        if (nodes_cfg_reg == '0)
        begin
            pillar_len = COUNT_W'(1);
        end
        else if (nodes_cfg_reg > MAX_N)
        begin
            pillar_len = MAX_N;
        end
        else
        begin
            pillar_len = nodes_cfg_reg;
        end
    end

    // Stack slot of the current node and the count after it
    assign base_cnt = (node_count_reg >= MAX_N) ? '0 : node_count_reg;
    assign new_cnt  = base_cnt + COUNT_W'(1);

    // Round to nearest, ties away from zero, then saturate
    assign rounded = {1'b0, absp_reg} + ROUND_HALF;
    assign mag     = rounded[64:16];

    always_comb
    begin
        if (mag == '0)
        begin
            corner_val = '0;
        end
        else if (neg_reg)
        begin
            corner_val = (mag >= 49'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        end
        else
        begin
            corner_val = (mag > 49'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
    end

    // Datapath stages of the shared scaling unit
    assign sum_next  = {depth_reg[corner_idx_reg][DEPTH_W-1], depth_reg[corner_idx_reg]}
                     + {offset_cfg_reg[DEPTH_W-1], offset_cfg_reg};
    assign prod_next = sum_reg * $signed(scale_cfg_reg);
    assign neg_next  = prod_reg[64];
    assign absp_next = prod_reg[64] ? 64'(-prod_reg) : prod_reg[63:0];

    assign row_wdata = {corner_reg[3], corner_reg[2], corner_reg[1], corner_reg[0]};
    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_re    = (state_reg == ST_RD);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        corner_idx_next = corner_idx_reg;
        drain_idx_next  = drain_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    corner_idx_next = 2'd0;
                    state_next      = split_ok ? ST_SUM : ST_ERR;
                end
            end
            ST_SUM:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                state_next = ST_RND;
            end
            ST_RND:
            begin
                if (single_reg || (corner_idx_reg == 2'd3))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    corner_idx_next = corner_idx_reg + 2'd1;
                    state_next      = ST_SUM;
                end
            end
            ST_WRITE:
            begin
                if (new_cnt < pillar_len)
                begin
                    node_count_next = new_cnt;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    node_count_next = new_cnt;
                    drain_idx_next  = AW'(new_cnt - COUNT_W'(1));
                    state_next      = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = row_rdata;
                    out_last_next   = (drain_idx_reg == '0);
                    out_status_next = 1'b0;
                    if (drain_idx_reg == '0)
                    begin
                        node_count_next = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg - AW'(1);
                        state_next     = ST_RD;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = 1'b1;
                    node_count_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            corner_idx_reg <= '0;
            drain_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            corner_idx_reg <= corner_idx_next;
            drain_idx_reg  <= drain_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_cfg_reg  <= NODES_RESET;
            offset_cfg_reg <= OFFSET_RESET;
            scale_cfg_reg  <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODES_PER_PILLAR: nodes_cfg_reg  <= cfg_data[COUNT_W-1:0];
                CFG_Z_OFFSET:         offset_cfg_reg <= cfg_data;
                CFG_Z_SCALE:          scale_cfg_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Payload: latch node, run datapath stages, collect corners
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            single_reg   <= (in_split == SPLIT_SINGLE);
            depth_reg[0] <= s_tdata[SPLIT_W +: DEPTH_W];
            depth_reg[1] <= s_tdata[SPLIT_W + DEPTH_W +: DEPTH_W];
            depth_reg[2] <= s_tdata[SPLIT_W + 2*DEPTH_W +: DEPTH_W];
            depth_reg[3] <= s_tdata[SPLIT_W + 3*DEPTH_W +: DEPTH_W];
        end
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        absp_reg <= absp_next;
        neg_reg  <= neg_next;
        if (state_reg == ST_RND)
        begin
            if (single_reg)
            begin
                corner_reg[0] <= corner_val;
                corner_reg[1] <= corner_val;
                corner_reg[2] <= corner_val;
                corner_reg[3] <= corner_val;
            end
            else
            begin
                corner_reg[corner_idx_reg] <= corner_val;
            end
        end
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // Node stack, one row of four corners per node
    snpce_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (base_cnt[AW-1:0]),
        .wdata (row_wdata),
        .re    (ram_re),
        .raddr (drain_idx_reg),
        .rdata (row_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    // Checks
    `SNPCE_ASSERT_IMP(a_count_range, 1'b1, node_count_reg <= MAX_N, "node count past stack depth")
    `SNPCE_ASSERT_IMP(a_err_item, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "bad error item")
    `SNPCE_ASSERT_NXT(a_busy_after_accept, in_accept, !s_tready, "ready right after accept")
    `SNPCE_ASSERT_NXT(a_drain_count, (state_reg == ST_WRITE) && (new_cnt >= pillar_len), node_count_reg == pillar_len || node_count_reg > pillar_len, "drain started early")

endmodule

// ===== dv/pillar_corner_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pillar corner checker
// Watches the node, corner and register channels of the pillar corner
// expander. Keeps its own node stack and register copy, works out the corner
// rows each accepted node causes, and compares each accepted row in order.
// ----------------------------------------------------------------------------
module pillar_corner_checker
    import snpce_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [ROW_W-1:0]     m_tdata,
    input  logic                 m_tlast,
    input  logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DEPTH_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   rows_pending,
    output int                   rows_checked
);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_SPLIT = 1'b1;

    typedef struct packed {
        logic [CORNERS-1:0][DEPTH_W-1:0] corner;
        logic                            last;
        logic                            status;
    } corner_row_t;

    // Register copy and node stack
    logic [COUNT_W-1:0] pillar_nodes;
    depth_t             depth_offset;
    depth_t             depth_scale;
    depth_t             node_stack [MAX_NODES][CORNERS];
    int                 nodes_held;

    corner_row_t        rows_due [$];
    int                 fails = 0;
    int                 rows_done = 0;

    // (z + offset) * scale in Q24.8 x Q16.16, rounded half away from zero
    function automatic depth_t scaled_depth(depth_t z, depth_t offs, depth_t scl);
        logic signed [33:0] sum;
        logic [33:0]        sum_mag;
        logic [32:0]        scl_mag;
        logic [63:0]        mag;
        logic               neg;
        sum     = {{2{z[31]}}, z} + {{2{offs[31]}}, offs};
        neg     = sum[33] ^ scl[31];
        sum_mag = sum[33] ? 34'(-sum) : 34'(sum);
        scl_mag = scl[31] ? 33'(-{1'b1, scl}) : {1'b0, scl};
        mag     = (64'(sum_mag) * 64'(scl_mag) + 64'h8000) >> 16;
        if (mag == 64'd0)
            return '0;
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - mag[31:0]);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Stack one node; on pillar completion queue its rows, last node first
    task automatic take_node(logic [IN_W-1:0] item);
        logic [SPLIT_W-1:0] split;
        depth_t             depth [CORNERS];
        corner_row_t        row;
        int                 len;
        int                 slot;
        int                 k;
        int                 n;
        split = item[SPLIT_W-1:0];
        for (k = 0; k < CORNERS; k++)
            depth[k] = item[SPLIT_W + k * DEPTH_W +: DEPTH_W];
        if (split != SPLIT_SINGLE && split != SPLIT_QUAD)
        begin
            // Bad split code: one zero row and the partial pillar is lost
            nodes_held = 0;
            row        = '0;
            row.last   = 1'b1;
            row.status = STATUS_BAD_SPLIT;
            rows_due.push_back(row);
        end
        else
        begin
            slot = nodes_held % MAX_NODES;
            for (k = 0; k < CORNERS; k++)
                node_stack[slot][k] = scaled_depth((split == SPLIT_QUAD) ? depth[k] : depth[0],
                                                   depth_offset, depth_scale);
            nodes_held = slot + 1;
            len = int'(pillar_nodes);
            if (len < 1)
                len = 1;
            if (len > MAX_NODES)
                len = MAX_NODES;
            // A length lowered mid-pillar flushes everything held
            if (nodes_held >= len)
            begin
                for (n = nodes_held - 1; n >= 0; n--)
                begin
                    for (k = 0; k < CORNERS; k++)
                        row.corner[k] = node_stack[n][k];
                    row.last   = (n == 0);
                    row.status = STATUS_OK;
                    rows_due.push_back(row);
                end
                nodes_held = 0;
            end
        end
    endtask

    // Compare one accepted row against the oldest one due
    task automatic check_row();
        corner_row_t due;
        int          k;
        if (rows_due.size() == 0)
        begin
            $display("%0t: corner row with none expected: data %h last %b status %b",
                     $time, m_tdata, m_tlast, m_tuser);
            fails++;
        end
        else
        begin
            due = rows_due.pop_front();
            for (k = 0; k < CORNERS; k++)
            begin
                if (due.corner[k] !== m_tdata[k * DEPTH_W +: DEPTH_W])
                begin
                    $display("%0t: corner %0d expected %h actual %h",
                             $time, k, due.corner[k], m_tdata[k * DEPTH_W +: DEPTH_W]);
                    fails++;
                end
            end
            if (due.last !== m_tlast)
            begin
                $display("%0t: last_of_pillar expected %b actual %b", $time, due.last, m_tlast);
                fails++;
            end
            if (due.status !== m_tuser)
            begin
                $display("%0t: status expected %b actual %b", $time, due.status, m_tuser);
                fails++;
            end
            rows_done++;
        end
    endtask

    // Track writes, nodes and rows on each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pillar_nodes = NODES_RESET;
            depth_offset = OFFSET_RESET;
            depth_scale  = SCALE_RESET;
            nodes_held   = 0;
            rows_due.delete();
            rows_pending <= 0;
            fail_count   <= fails;
            rows_checked <= rows_done;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NODES_PER_PILLAR: pillar_nodes = cfg_data[COUNT_W-1:0];
                    CFG_Z_OFFSET:         depth_offset = cfg_data;
                    CFG_Z_SCALE:          depth_scale  = cfg_data;
                    default:              ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_node(s_tdata);
            if (m_tvalid && m_tready)
                check_row();
            rows_pending <= rows_due.size();
            fail_count   <= fails;
            rows_checked <= rows_done;
        end
    end

endmodule

// ===== dv/split_node_pillar_corner_expander_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pillar corner expander testbench
// Drives nodes and register writes into the expander with random gaps and
// output stalls, including one long output hold-off, and leaves prediction
// and comparison to the checker beside it. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module split_node_pillar_corner_expander_tb;
    import snpce_pkg::*;

    localparam int MAX_NODES   = 64;
    localparam int PHASES      = 8;
    localparam int DRAIN_SLACK = 40;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [SPLIT_W-1:0]   BAD_SPLIT_LOW  = 8'h00;
    localparam logic [SPLIT_W-1:0]   BAD_SPLIT_HIGH = 8'hFF;

    localparam depth_t DEPTH_MAX = 32'h7FFF_FFFF;
    localparam depth_t DEPTH_MIN = 32'h8000_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ROW_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DEPTH_W-1:0]   cfg_data;

    int   fail_count;
    int   rows_pending;
    int   rows_checked;
    int   cycle_count = 0;
    int   nodes_sent;
    int   bad_sent;
    int   settings_used;
    logic steady;
    logic hold_req;
    logic hold_done;
    int   stall_left;
    int   phase_items [PHASES] = '{40, 30, 50, 70, 30, 70, 60, 50};

    split_node_pillar_corner_expander #(
        .MAX_NODES (MAX_NODES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pillar_corner_checker #(
        .MAX_NODES (MAX_NODES)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending),
        .rows_checked (rows_checked)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("** split_node_pillar_corner_expander: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    function automatic depth_t pick_depth();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        if (r < 70)
            return $urandom_range(0, 32'h7FFF) - 32'h4000;
        if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return DEPTH_MAX;
                1:       return DEPTH_MIN;
                2:       return '0;
                3:       return '1;
                default: return 32'd1;
            endcase
        end
        return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    endfunction

    function automatic depth_t pick_offset();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
        if (r < 70)
            return $urandom;
        if (r < 85)
            return $urandom_range(0, 1) ? DEPTH_MAX : DEPTH_MIN;
        return '0;
    endfunction

    function automatic depth_t pick_scale();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SCALE_RESET + $urandom_range(0, 32'h8000) - 32'h4000;
        if (r < 60)
            return $urandom_range(0, 32'h800) - 32'h400;
        if (r < 80)
            return $urandom;
        if (r < 90)
            return $urandom_range(0, 1) ? DEPTH_MAX : DEPTH_MIN;
        return 32'hFFFF_0000 + $urandom_range(0, 32'h8000) - 32'h4000;
    endfunction

    function automatic logic [SPLIT_W-1:0] pick_bad_split();
        logic [SPLIT_W-1:0] code;
        do
            code = SPLIT_W'($urandom_range(0, 255));
        while (code == SPLIT_SINGLE || code == SPLIT_QUAD);
        return code;
    endfunction

    // Offer one node and hold it until taken; valid stays high afterwards
    task automatic send_node(logic [SPLIT_W-1:0] split, depth_t a, depth_t b, depth_t c,
                             depth_t d);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, c, b, a, split};
        do
            @(posedge clk);
        while (!s_tready);
        if (split == SPLIT_SINGLE || split == SPLIT_QUAD)
            nodes_sent++;
        else
            bad_sent++;
    endtask

    // One register write; valid stays high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEPTH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all three registers; junk above the node count field
    task automatic configure(logic [COUNT_W-1:0] nodes, depth_t offs, depth_t scl);
        logic [DEPTH_W-1:0] junk;
        junk = $urandom;
        write_reg(CFG_NODES_PER_PILLAR, {junk[DEPTH_W-1:COUNT_W], nodes});
        write_reg(CFG_Z_OFFSET, offs);
        write_reg(CFG_Z_SCALE, scl);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Drop valid, wait for every due row, then let a node in flight finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rows_pending != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Mostly good nodes with random content, a few bad split codes
    task automatic send_random(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                send_node(pick_bad_split(), pick_depth(), pick_depth(), pick_depth(),
                          pick_depth());
            else
                send_node($urandom_range(0, 1) ? SPLIT_QUAD : SPLIT_SINGLE, pick_depth(),
                          pick_depth(), pick_depth(), pick_depth());
        end
    endtask

    // Output ready: random stalls, one long hold-off on request
    initial
    begin
        m_tready   = 1'b0;
        hold_done  = 1'b0;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (steady)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [COUNT_W-1:0] nodes;
        depth_t             offs;
        depth_t             scl;
        int                 p;
        int                 i;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_NODES_PER_PILLAR;
        cfg_data      = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        nodes_sent    = 0;
        bad_sent      = 0;
        settings_used = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: bad codes alone and dropping a partial pillar
        send_node(BAD_SPLIT_LOW, '0, '0, '0, '0);
        send_node(SPLIT_SINGLE, 32'h100, pick_depth(), pick_depth(), pick_depth());
        send_node(SPLIT_QUAD, DEPTH_MAX, DEPTH_MIN, '0, '1);
        send_node(BAD_SPLIT_HIGH, '1, '1, '1, '1);
        settle();

        // Unused register index, pillar length zero, positive extremes
        write_reg(CFG_UNUSED, $urandom);
        configure(7'd0, DEPTH_MAX, DEPTH_MAX);
        send_node(SPLIT_QUAD, DEPTH_MAX, DEPTH_MIN, '0, '1);
        send_node(SPLIT_SINGLE, DEPTH_MAX, pick_depth(), pick_depth(), pick_depth());
        settle();

        // Negative extremes, including the largest magnitude product
        configure(7'd0, DEPTH_MIN, DEPTH_MIN);
        send_node(SPLIT_QUAD, DEPTH_MIN, DEPTH_MAX, 32'd1, '0);
        settle();

        // Rounding ties with the smallest scales of either sign
        configure(7'd0, '0, 32'd1);
        send_node(SPLIT_QUAD, 32'h8000, -32'sh8000, 32'h7FFF, -32'sh7FFF);
        settle();
        configure(7'd0, '0, '1);
        send_node(SPLIT_QUAD, 32'h8000, -32'sh8000, 32'h7FFF, -32'sh7FFF);
        settle();

        // Lower the pillar length below the nodes already held
        configure(7'd8, '0, SCALE_RESET);
        for (i = 0; i < 5; i++)
            send_node(SPLIT_QUAD, pick_depth(), pick_depth(), pick_depth(), pick_depth());
        settle();
        configure(7'd3, 32'h100, 32'h1_8000);
        send_node(SPLIT_SINGLE, pick_depth(), pick_depth(), pick_depth(), pick_depth());
        settle();

        // Random phases over pillar lengths, offsets and scales
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       nodes = NODES_RESET;
                1:       nodes = 7'd1;
                2:       nodes = COUNT_W'($urandom_range(2, 6));
                3:       nodes = 7'd64;
                4:       nodes = 7'd0;
                5:       nodes = 7'd127;
                default: nodes = COUNT_W'($urandom_range(1, 12));
            endcase
            offs = (p == 0) ? OFFSET_RESET : pick_offset();
            scl  = (p == 0) ? SCALE_RESET : pick_scale();
            configure(nodes, offs, scl);
            steady   <= (p == 4);
            hold_req <= (p == 2);
            send_random(phase_items[p]);
            settle();
        end

        $display("Sent %0d nodes and %0d bad split codes under %0d register settings,",
                 nodes_sent, bad_sent, settings_used);
        $display("checked %0d corner rows, with one %0d-cycle output hold-off.",
                 rows_checked, HOLD_CYCLES);
        if (fail_count == 0 && rows_pending == 0)
            $display("** split_node_pillar_corner_expander: PASSED **");
        else
            $display("** split_node_pillar_corner_expander: FAILED **");
        $finish;
    end

endmodule

// ===== split_node_pillar_corner_expander.f =====
+incdir+src
src/snpce_pkg.sv
src/snpce_ram.sv
src/split_node_pillar_corner_expander.sv
dv/pillar_corner_checker.sv
dv/split_node_pillar_corner_expander_tb.sv
